/* src/fwbc_pkg.sv */
// shared types, codes and helpers of the block cache directory
`default_nettype none
package fwbc_pkg;

  localparam int CFG_W = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_FLUSH = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  localparam logic [1:0] KIND_FETCH      = 2'd0;
  localparam logic [1:0] KIND_WRITEBACK  = 2'd1;
  localparam logic [1:0] KIND_ACCESS_END = 2'd2;
  localparam logic [1:0] KIND_FLUSH_END  = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  file_id;
    logic [31:0] block_number;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  slot_index;
    logic [7:0]  out_file_id;
    logic [31:0] out_block_number;
    logic        was_hit;
    logic        last_result;
  } res_t;

  typedef struct packed {
    logic [7:0]  file_id;
    logic [31:0] block_number;
  } tag_t;

  typedef struct packed {
    logic hit;
    logic wb;
  } match_t;

  function automatic res_t make_res(input logic [1:0] kind, input logic [3:0] slot,
                                    input logic [7:0] file, input logic [31:0] block,
                                    input logic hit, input logic last);
    res_t r;
    r.kind             = kind;
    r.slot_index       = slot;
    r.out_file_id      = file;
    r.out_block_number = block;
    r.was_hit          = hit;
    r.last_result      = last;
    return r;
  endfunction

endpackage
`default_nettype wire

/* src/fwbc_ram.sv */
// generic single-write, registered-read ram
`default_nettype none
module fwbc_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* src/fwbc_match.sv */
// shared tag compare unit: ring validity, tag match and flush selection
`default_nettype none
module fwbc_match #(
  parameter int SLOTS = 16
) (
  input  wire logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] slot,
  input  wire logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] head,
  input  wire logic [$clog2(SLOTS+1)-1:0]                 count,
  input  wire fwbc_pkg::tag_t                             entry,
  input  wire logic                                       dirty,
  input  wire fwbc_pkg::req_t                             cur,
  output fwbc_pkg::match_t                                result
);
  import fwbc_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int DW = SW + 1;

  logic [DW-1:0] s_ext;
  logic [DW-1:0] h_ext;
  logic [DW-1:0] span;
  logic          valid;
  logic          file_eq;

  always_comb begin
    s_ext = DW'(slot);
    h_ext = DW'(head);
    // distance from the oldest entry around the ring
    if (s_ext >= h_ext) begin
      span = s_ext - h_ext;
    end else begin
      span = s_ext + DW'(SLOTS) - h_ext;
    end
    valid   = 8'(span) < 8'(count);
    file_eq = entry.file_id == cur.file_id;
    result.hit = valid && (cur.req_type != REQ_FLUSH) && file_eq
                 && (entry.block_number == cur.block_number);
    result.wb  = valid && (cur.req_type == REQ_FLUSH) && file_eq && dirty;
  end

endmodule
`default_nettype wire

/* src/fifo_writeback_block_cache_directory.sv */
// top level: request sequencer, dirty marks and fifo ring of the cache directory
`default_nettype none
// Directory of a fully associative write-back cache with FIFO replacement.
// A request is taken when start is high and busy is low; results come out at
// most one per cycle on result, each marked by a one-cycle strobe, and cannot
// be held off. All tags sit in one ram and are checked by a single compare
// unit, one slot per cycle, so a request walks the slots in ascending order.
// A hit ends the walk at the matching slot. A miss walks every slot, then
// gives the optional write-back of the oldest line, the fetch and the done
// beat; a flush walks every slot and then gives its end beat, its write-back
// beats overlapping the walk. The last beat of a request is on the ports in
// the first cycle with busy low, and a new request can be taken at the edge
// that ends that cycle. An unused request code is not taken, gives no result
// and leaves busy low.
module fifo_writeback_block_cache_directory #(
  parameter int SLOTS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire fwbc_pkg::req_t  req,
  input  wire logic            cfg_we,
  input  wire logic [4:0]      cfg_data,
  output logic                 strobe,
  output fwbc_pkg::res_t       result
);
  import fwbc_pkg::*;

  localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW   = $clog2(SLOTS + 1);
  localparam int SUMW = CW + 1;
  localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_MISS, ST_FETCH, ST_DONE, ST_FDONE
  } state_t;

  state_t          state;
  req_t            cur;
  logic [SW-1:0]   cmp_slot;
  logic [SW-1:0]   vslot;
  logic [SW-1:0]   ring_head;
  logic [CW-1:0]   fill_count;
  logic [CFG_W-1:0] slots_in_use;
  logic [SLOTS-1:0] dirty;
  res_t            res;

  logic [SW-1:0]   ram_raddr;
  tag_t            ram_rdata;
  logic            ram_we;
  tag_t            ram_wdata;
  match_t          match;

  logic [7:0]      lim;
  logic            evict;
  logic [SUMW-1:0] sum;
  logic [SW-1:0]   victim;
  logic [SW-1:0]   head_next;

  assign busy   = (state != ST_IDLE);
  assign result = res;

  fwbc_ram #(
    .WIDTH ($bits(tag_t)),
    .DEPTH (SLOTS)
  ) u_tags (
    .clk   (clk),
    .we    (ram_we),
    .waddr (victim),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fwbc_match #(
    .SLOTS (SLOTS)
  ) u_match (
    .slot   (cmp_slot),
    .head   (ring_head),
    .count  (fill_count),
    .entry  (ram_rdata),
    .dirty  (dirty[cmp_slot]),
    .cur    (cur),
    .result (match)
  );

  always_comb begin
    // effective slot limit: zero acts as one, clipped to the ring size
    if (slots_in_use == '0) begin
      lim = 8'd1;
    end else if (8'(slots_in_use) > 8'(SLOTS)) begin
      lim = 8'(SLOTS);
    end else begin
      lim = 8'(slots_in_use);
    end
    evict = 8'(fill_count) >= lim;
    sum   = SUMW'(ring_head) + SUMW'(fill_count);
    if (evict) begin
      victim = ring_head;
    end else if (sum >= SUMW'(SLOTS)) begin
      victim = SW'(sum - SUMW'(SLOTS));
    end else begin
      victim = SW'(sum);
    end
    head_next = (victim == LAST) ? '0 : SW'(victim + 1'b1);

    ram_we              = (state == ST_MISS);
    ram_wdata.file_id      = cur.file_id;
    ram_wdata.block_number = cur.block_number;

    // read runs one slot ahead of the compare; after the last slot fetch the oldest
    case (state)
      ST_SCAN: begin
        if (cmp_slot == LAST) begin
          ram_raddr = ring_head;
        end else begin
          ram_raddr = SW'(cmp_slot + 1'b1);
        end
      end
      default: begin
        ram_raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      strobe       <= 1'b0;
      dirty        <= '0;
      ring_head    <= '0;
      fill_count   <= '0;
      slots_in_use <= CFG_RESET;
    end else begin
      strobe <= 1'b0;
      if (cfg_we) begin
        slots_in_use <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (start && req.req_type != REQ_NONE) begin
            cur      <= req;
            cmp_slot <= '0;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (match.hit) begin
            if (cur.req_type == REQ_WRITE) begin
              dirty[cmp_slot] <= 1'b1;
            end
            strobe <= 1'b1;
            res    <= make_res(KIND_ACCESS_END, 4'(cmp_slot), cur.file_id,
                               cur.block_number, 1'b1, 1'b1);
            state  <= ST_IDLE;
          end else begin
            if (match.wb) begin
              dirty[cmp_slot] <= 1'b0;
              strobe <= 1'b1;
              res    <= make_res(KIND_WRITEBACK, 4'(cmp_slot), cur.file_id,
                                 ram_rdata.block_number, 1'b0, 1'b0);
            end
            if (cmp_slot == LAST) begin
              state <= (cur.req_type == REQ_FLUSH) ? ST_FDONE : ST_MISS;
            end else begin
              cmp_slot <= SW'(cmp_slot + 1'b1);
            end
          end
        end
        ST_MISS: begin
          vslot <= victim;
          if (evict) begin
            if (dirty[victim]) begin
              strobe <= 1'b1;
              res    <= make_res(KIND_WRITEBACK, 4'(victim), ram_rdata.file_id,
                                 ram_rdata.block_number, 1'b0, 1'b0);
            end
            ring_head <= head_next;
          end else begin
            fill_count <= CW'(fill_count + 1'b1);
          end
          dirty[victim] <= (cur.req_type == REQ_WRITE);
          state <= ST_FETCH;
        end
        ST_FETCH: begin
          strobe <= 1'b1;
          res    <= make_res(KIND_FETCH, 4'(vslot), cur.file_id, cur.block_number,
                             1'b0, 1'b0);
          state  <= ST_DONE;
        end
        ST_DONE: begin
          strobe <= 1'b1;
          res    <= make_res(KIND_ACCESS_END, 4'(vslot), cur.file_id, cur.block_number,
                             1'b0, 1'b1);
          state  <= ST_IDLE;
        end
        ST_FDONE: begin
          strobe <= 1'b1;
          res    <= make_res(KIND_FLUSH_END, 4'd0, cur.file_id, 32'd0, 1'b0, 1'b1);
          state  <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
